// ===== hw/rtl/rrs_pkg.sv =====
// round-robin schedule simulator: shared constants, beat types and the
// command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int RING_DEPTH = 16;

  localparam int PID_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int RING_AW   = $clog2(RING_DEPTH);
  localparam int RING_CW   = $clog2(RING_DEPTH + 1);
  localparam int ARR_W     = 16;
  localparam int BUR_W     = 16;
  localparam int QNT_W     = 16;
  localparam int TIME_W    = 22;
  localparam int PROC_ID_W = 4;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_IW = APB_AW - 2;

  localparam logic [REG_IW-1:0] REG_QUANTUM   = '0;
  localparam logic [QNT_W-1:0]  QUANTUM_RESET = 16'd4;

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic             last_process;
  } in_item_t;

  typedef struct packed {
    logic [PROC_ID_W-1:0] process_id;
    logic [TIME_W-1:0]    completion_time;
    logic [TIME_W-1:0]    turnaround_time;
    logic [TIME_W-1:0]    waiting_time;
    logic                 last_result;
  } out_item_t;

  typedef struct packed {
    logic load_en;
    logic key;
    logic cmp;
    logic place;
    logic init;
    logic idx_clr;
    logic find;
    logic scan;
    logic skip;
    logic pop;
    logic slice;
    logic run;
    logic repush;
    logic out_calc;
    logic out_load;
  } rrs_cmd_t;

  typedef struct packed {
    logic start;
    logic j_last;
    logic s_last;
    logic found;
    logic all_fin;
    logic ring_empty;
    logic out_free;
  } rrs_stat_t;

endpackage

// ===== hw/rtl/rrs_ctrl.sv =====
// round-robin schedule simulator: sequencing state machine
// depends on rrs_pkg (command and status structs)
`timescale 1ns / 1ps

module rrs_ctrl import rrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rrs_stat_t stat,
  output rrs_cmd_t  cmd
);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_KEY      = 4'd1;
  localparam logic [3:0] S_CMP      = 4'd2;
  localparam logic [3:0] S_PLACE    = 4'd3;
  localparam logic [3:0] S_INIT     = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_FIND     = 4'd6;
  localparam logic [3:0] S_SCAN     = 4'd7;
  localparam logic [3:0] S_POP      = 4'd8;
  localparam logic [3:0] S_SLICE    = 4'd9;
  localparam logic [3:0] S_RUN      = 4'd10;
  localparam logic [3:0] S_REPUSH   = 4'd11;
  localparam logic [3:0] S_OUT_CALC = 4'd12;
  localparam logic [3:0] S_OUT_LOAD = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       after_run_r, after_run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      after_run_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_run_r <= after_run_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    after_run_nxt = after_run_r;
    case (state_r)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (stat.start) state_nxt = S_KEY;
      end
      S_KEY: begin
        cmd.key   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.j_last) state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = stat.s_last ? S_INIT : S_KEY;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.idx_clr = 1'b1;
        if (stat.all_fin) begin
          state_nxt = S_OUT_CALC;
        end else if (stat.ring_empty) begin
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_FIND: begin
        // idle forward to the earliest unfinished arrival, then scan all
        cmd.find = 1'b1;
        if (stat.found) begin
          state_nxt     = S_SCAN;
          after_run_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        cmd.skip = after_run_r;
        if (stat.s_last) state_nxt = after_run_r ? S_REPUSH : S_POP;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_SLICE;
      end
      S_SLICE: begin
        cmd.slice = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.run       = 1'b1;
        state_nxt     = S_SCAN;
        after_run_nxt = 1'b1;
      end
      S_REPUSH: begin
        cmd.repush = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_OUT_CALC: begin
        cmd.out_calc = 1'b1;
        state_nxt    = S_OUT_LOAD;
      end
      S_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        if (stat.out_free) state_nxt = stat.s_last ? S_LOAD : S_OUT_CALC;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrs_datapath.sv =====
// round-robin schedule simulator: process stores, ready ring, sim clock,
// sort/scan index counters and the result register
// depends on rrs_pkg (types, widths, command and status structs)
`timescale 1ns / 1ps

module rrs_datapath import rrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [QNT_W-1:0] quantum,
  input  rrs_cmd_t         cmd,
  output rrs_stat_t        stat,
  input  logic             in_valid,
  input  in_item_t         in_data,
  input  logic             out_stall,
  output logic             out_valid,
  output out_item_t        out_data
);

  logic [ARR_W-1:0]  arr_mem  [MAX_PROCS];
  logic [BUR_W-1:0]  bur_mem  [MAX_PROCS];
  logic [BUR_W-1:0]  rem_mem  [MAX_PROCS];
  logic [TIME_W-1:0] fin_mem  [MAX_PROCS];
  logic [PID_W-1:0]  ord_mem  [MAX_PROCS];
  logic [PID_W-1:0]  ring_mem [RING_DEPTH];

  logic [MAX_PROCS-1:0] done_r, inring_r;
  logic [CNT_W-1:0]     cnt_r, fin_cnt_r;
  logic [PID_W-1:0]     s_r, j_r;
  logic [RING_AW-1:0]   head_r, tail_r;
  logic [RING_CW-1:0]   rcnt_r;
  logic [TIME_W-1:0]    clock_r;
  logic                 out_valid_r;

  logic [PID_W-1:0]  p_r, rank_r;
  logic [ARR_W-1:0]  key_r;
  logic [QNT_W-1:0]  run_r;
  logic [TIME_W-1:0] ct_r, tat_r;
  out_item_t         out_r;

  logic              accept;
  logic [CNT_W-1:0]  cnt_m1;
  logic              s_last, j_last, out_free;
  logic [PID_W-1:0]  p_ord, arr_addr, push_id;
  logic [ARR_W-1:0]  arr_rd;
  logic [BUR_W-1:0]  bur_rd, rem_p;
  logic [TIME_W-1:0] fin_rd, clock_sum;
  logic [QNT_W-1:0]  q_eff, run_nxt;
  logic              less, cand_ok, ring_full, push_en, found, slice_done;

  assign accept   = in_valid & cmd.load_en;
  assign cnt_m1   = cnt_r - 1'b1;
  assign s_last   = (CNT_W'(s_r) == cnt_m1);
  assign j_last   = (CNT_W'(j_r) == cnt_m1);
  assign out_free = ~out_valid_r | ~out_stall;

  assign p_ord = ord_mem[s_r];

  always_comb begin
    if (cmd.cmp) begin
      arr_addr = j_r;
    end else if (cmd.find | cmd.scan) begin
      arr_addr = p_ord;
    end else begin
      arr_addr = s_r;
    end
  end

  assign arr_rd = arr_mem[arr_addr];
  assign bur_rd = bur_mem[s_r];
  assign fin_rd = fin_mem[s_r];
  assign rem_p  = rem_mem[p_r];

  // stable rank: earlier arrival, or equal arrival and earlier input slot
  assign less = (arr_rd < key_r) | ((arr_rd == key_r) & (j_r < s_r));

  assign found   = ~done_r[p_ord];
  assign cand_ok = ~(cmd.skip & (p_ord == p_r)) & ~done_r[p_ord] & ~inring_r[p_ord]
                 & (TIME_W'(arr_rd) <= clock_r);

  assign ring_full = (rcnt_r == RING_CW'(RING_DEPTH));
  assign push_en   = ~ring_full & ((cmd.scan & cand_ok)
                   | (cmd.repush & ~done_r[p_r] & ~inring_r[p_r]));
  assign push_id   = cmd.scan ? p_ord : p_r;

  assign q_eff      = (quantum == '0) ? QNT_W'(1) : quantum;
  assign run_nxt    = (rem_p < q_eff) ? rem_p : q_eff;
  assign clock_sum  = clock_r + TIME_W'(run_r);
  assign slice_done = (rem_p == run_r);

  assign stat.start      = accept & in_data.last_process;
  assign stat.j_last     = j_last;
  assign stat.s_last     = s_last;
  assign stat.found      = found;
  assign stat.all_fin    = (fin_cnt_r == cnt_r);
  assign stat.ring_empty = (rcnt_r == '0);
  assign stat.out_free   = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      inring_r    <= '0;
      cnt_r       <= '0;
      fin_cnt_r   <= '0;
      s_r         <= '0;
      j_r         <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      rcnt_r      <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && (cnt_r < CNT_W'(MAX_PROCS))) cnt_r <= cnt_r + 1'b1;
      if (stat.start) s_r <= '0;

      if (cmd.key) j_r <= '0;
      if (cmd.cmp) j_r <= j_r + 1'b1;
      if (cmd.place) s_r <= s_r + 1'b1;
      if (cmd.idx_clr) s_r <= '0;

      if (cmd.init) begin
        done_r    <= '0;
        inring_r  <= '0;
        fin_cnt_r <= '0;
        head_r    <= '0;
        tail_r    <= '0;
        rcnt_r    <= '0;
        clock_r   <= '0;
      end

      if (cmd.find) begin
        if (found) begin
          s_r <= '0;
          if (clock_r < TIME_W'(arr_rd)) clock_r <= TIME_W'(arr_rd);
        end else begin
          s_r <= s_r + 1'b1;
        end
      end

      if (cmd.scan) s_r <= s_last ? '0 : s_r + 1'b1;

      if (push_en) begin
        tail_r            <= (tail_r == RING_AW'(RING_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        rcnt_r            <= rcnt_r + 1'b1;
        inring_r[push_id] <= 1'b1;
      end

      if (cmd.pop) begin
        head_r                     <= (head_r == RING_AW'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
        rcnt_r                     <= rcnt_r - 1'b1;
        inring_r[ring_mem[head_r]] <= 1'b0;
      end

      if (cmd.run) begin
        s_r     <= '0;
        clock_r <= clock_sum;
        if (slice_done) begin
          done_r[p_r] <= 1'b1;
          fin_cnt_r   <= fin_cnt_r + 1'b1;
        end
      end

      if (cmd.out_load && out_free) begin
        out_valid_r <= 1'b1;
        s_r         <= s_r + 1'b1;
        if (s_last) cnt_r <= '0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stores and payload registers
  always_ff @(posedge clk) begin
    if (accept && (cnt_r < CNT_W'(MAX_PROCS))) begin
      arr_mem[cnt_r[PID_W-1:0]] <= in_data.arrival_time;
      bur_mem[cnt_r[PID_W-1:0]] <= in_data.burst_time;
    end
    if (cmd.key) begin
      key_r        <= arr_rd;
      rank_r       <= '0;
      rem_mem[s_r] <= bur_rd;
    end
    if (cmd.cmp && less) rank_r <= rank_r + 1'b1;
    if (cmd.place) ord_mem[rank_r] <= s_r;
    if (push_en) ring_mem[tail_r] <= push_id;
    if (cmd.pop) p_r <= ring_mem[head_r];
    if (cmd.slice) run_r <= run_nxt;
    if (cmd.run) begin
      rem_mem[p_r] <= rem_p - run_r;
      if (slice_done) fin_mem[p_r] <= clock_sum;
    end
    if (cmd.out_calc) begin
      ct_r  <= fin_rd;
      tat_r <= fin_rd - TIME_W'(arr_rd);
    end
    if (cmd.out_load && out_free) begin
      out_r.process_id      <= PROC_ID_W'(s_r);
      out_r.completion_time <= ct_r;
      out_r.turnaround_time <= tat_r;
      out_r.waiting_time    <= tat_r - TIME_W'(bur_rd);
      out_r.last_result     <= s_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/round_robin_schedule_simulator_top.sv =====
// round-robin schedule simulator: top level with the quantum register
// depends on rrs_pkg, rrs_ctrl and rrs_datapath
`timescale 1ns / 1ps

// Usage
// in_ channel: one process record (arrival, burst, last flag) per beat,
// one beat per cycle while loading; records past MAX_PROCS are dropped.
// The beat with last_process set starts the run; in_stall stays high until
// the final result of the run has been handed to the output register.
// Run, n records: an arrival sort, then per time slice a ready check, ring
// pop, slice, run, arrival scan over n entries and requeue, plus, for each
// stretch where the ring runs empty, a walk of the arrival-ordered list to
// the earliest unfinished process and then a full arrival scan.
// out_ channel: n results in input order, last_result on the last; out_stall
// holds the output register and pauses the sequencer.
// quantum sits at byte address 0 of the APB port (reset 4, zero acts as 1)
// and the user must write it only while the block is idle; nothing guards it.
// rst_n (synchronous) empties the record store and the result register.

module round_robin_schedule_simulator_top import rrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [QNT_W-1:0]  quantum_r;
  logic [REG_IW-1:0] reg_idx;
  rrs_cmd_t          cmd;
  rrs_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_QUANTUM)) begin
      quantum_r <= pwdata[QNT_W-1:0];
    end
  end

  assign prdata   = (reg_idx == REG_QUANTUM) ? APB_DW'(quantum_r) : '0;
  assign in_stall = ~cmd.load_en;

  rrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  rrs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .quantum   (quantum_r),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== dv/round_robin_schedule_simulator_top_test.sv =====
// testbench for the round-robin schedule simulator: directed and random
// process batches checked against an in-bench scheduling predictor
// depends on rrs_pkg and round_robin_schedule_simulator_top
`timescale 1ns / 1ps

module round_robin_schedule_simulator_top_test;
  import rrs_pkg::*;

  localparam int unsigned TIME_CEIL = (1 << TIME_W) - 1;
  localparam int unsigned RANDOM_BATCH_ITEMS = 125;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  round_robin_schedule_simulator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor state: quantum copy, loaded batch and the scheduler's working set
  logic [QNT_W-1:0] slice_len;
  logic [ARR_W-1:0] batch_arrival [MAX_PROCS];
  logic [BUR_W-1:0] batch_burst [MAX_PROCS];
  int unsigned      batch_count;
  int unsigned      sched_order [MAX_PROCS];
  int unsigned      remain [MAX_PROCS];
  int unsigned      finish_at [MAX_PROCS];
  bit               done_flag [MAX_PROCS];
  bit               queued [MAX_PROCS];
  int unsigned      ring_slot [RING_DEPTH];
  int unsigned      ring_head;
  int unsigned      ring_tail;
  int unsigned      ring_fill;
  int unsigned      sim_now;

  out_item_t   pending_results [$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned out_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("round_robin_schedule_simulator_top: mismatch");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: id %0d ct %0d tat %0d wt %0d last %0b",
                   out_data.process_id, out_data.completion_time,
                   out_data.turnaround_time, out_data.waiting_time, out_data.last_result);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected id %0d ct %0d tat %0d wt %0d last %0b,",
                      " got id %0d ct %0d tat %0d wt %0d last %0b"},
                     want.process_id, want.completion_time, want.turnaround_time,
                     want.waiting_time, want.last_result,
                     out_data.process_id, out_data.completion_time,
                     out_data.turnaround_time, out_data.waiting_time, out_data.last_result);
        end
      end
    end
  end

  function automatic void ring_push(int unsigned p);
    if (ring_fill < RING_DEPTH && !queued[p]) begin
      ring_slot[ring_tail] = p;
      ring_tail = (ring_tail + 1) % RING_DEPTH;
      ring_fill++;
      queued[p] = 1'b1;
    end
  endfunction

  // arrived, unfinished processes join the ring in arrival order
  function automatic void enqueue_arrived(int unsigned skip);
    int unsigned s;
    int unsigned p;
    for (s = 0; s < batch_count; s++) begin
      p = sched_order[s];
      if (p != skip && !done_flag[p] && !queued[p] && batch_arrival[p] <= sim_now)
        ring_push(p);
    end
  endfunction

  function automatic int unsigned clip_time(int unsigned v);
    return (v > TIME_CEIL) ? TIME_CEIL : v;
  endfunction

  function automatic void schedule_batch();
    int unsigned n;
    int unsigned s;
    int unsigned k;
    int unsigned p;
    int unsigned q;
    int unsigned run;
    int unsigned finished;
    int unsigned ct;
    int unsigned tat;
    out_item_t   r;
    n = batch_count;
    q = (slice_len == '0) ? 1 : slice_len;
    // stable insertion sort on arrival
    for (s = 0; s < n; s++) begin
      k = s;
      while (k > 0 && batch_arrival[sched_order[k-1]] > batch_arrival[s]) begin
        sched_order[k] = sched_order[k-1];
        k--;
      end
      sched_order[k] = s;
    end
    for (s = 0; s < n; s++) begin
      remain[s] = batch_burst[s];
      done_flag[s] = 1'b0;
      queued[s] = 1'b0;
      finish_at[s] = 0;
    end
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    sim_now = 0;
    finished = 0;
    while (finished < n) begin
      if (ring_fill == 0) begin
        // idle forward to the earliest unfinished arrival
        for (s = 0; s < n; s++) begin
          p = sched_order[s];
          if (!done_flag[p]) begin
            if (sim_now < batch_arrival[p])
              sim_now = batch_arrival[p];
            break;
          end
        end
        enqueue_arrived(MAX_PROCS);
      end
      p = ring_slot[ring_head] % MAX_PROCS;
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
      queued[p] = 1'b0;
      run = (remain[p] < q) ? remain[p] : q;
      sim_now += run;
      remain[p] -= run;
      if (remain[p] == 0) begin
        done_flag[p] = 1'b1;
        finish_at[p] = sim_now;
        finished++;
      end
      enqueue_arrived(p);
      if (!done_flag[p])
        ring_push(p);
    end
    for (s = 0; s < n; s++) begin
      ct = finish_at[s];
      tat = ct - batch_arrival[s];
      r.process_id = PROC_ID_W'(s);
      r.completion_time = TIME_W'(clip_time(ct));
      r.turnaround_time = TIME_W'(clip_time(tat));
      r.waiting_time = TIME_W'(clip_time(tat - batch_burst[s]));
      r.last_result = (s + 1 == n);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void record_loaded(in_item_t rec);
    if (batch_count < MAX_PROCS) begin
      batch_arrival[batch_count] = rec.arrival_time;
      batch_burst[batch_count] = rec.burst_time;
      batch_count++;
    end
    if (rec.last_process) begin
      schedule_batch();
      batch_count = 0;
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_record(logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur, logic last);
    in_item_t rec;
    rec.arrival_time = arr;
    rec.burst_time = bur;
    rec.last_process = last;
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk);
    in_valid = 1'b1;
    in_data = rec;
    do
      @(posedge clk);
    while (in_stall);
    record_loaded(rec);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0)
      @(posedge clk);
    // the block clears itself after the final beat of a run
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_quantum(logic [QNT_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_QUANTUM, 2'b00};
    pwdata = APB_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    do
      @(posedge clk);
    while (!pready);
    slice_len = value;
    @(negedge clk);
    // read back
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do
      @(posedge clk);
    while (!pready);
    if (prdata !== APB_DW'(slice_len)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("quantum readback: expected %0d, got %0d", slice_len, prdata);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_single_record();
    send_record(16'd3, 16'd5, 1'b1);
  endtask

  // arrival ties, a zero burst and preemption at the reset quantum
  task automatic test_mixed_batch();
    send_record(16'd0, 16'd5, 1'b0);
    send_record(16'd1, 16'd3, 1'b0);
    send_record(16'd1, 16'd8, 1'b0);
    send_record(16'd2, 16'd0, 1'b0);
    send_record(16'd4, 16'd2, 1'b1);
  endtask

  // the ring runs dry and the clock skips ahead to later arrivals
  task automatic test_arrival_gaps();
    send_record(16'd10, 16'd2, 1'b0);
    send_record(16'd100, 16'd3, 1'b0);
    send_record(16'd50, 16'd1, 1'b0);
    send_record(16'd52, 16'd6, 1'b1);
  endtask

  task automatic test_field_extremes();
    wait_idle();
    write_quantum(16'hFFFF);
    send_record(16'hFFFF, 16'hFFFF, 1'b0);
    send_record(16'h0000, 16'hFFFF, 1'b0);
    send_record(16'hFFFF, 16'h0001, 1'b0);
    send_record(16'h0000, 16'h0001, 1'b1);
  endtask

  task automatic test_zero_quantum();
    wait_idle();
    write_quantum(16'd0);
    send_record(16'd0, 16'd3, 1'b0);
    send_record(16'd1, 16'd2, 1'b0);
    send_record(16'd0, 16'd1, 1'b1);
  endtask

  task automatic test_random_batches(int unsigned send_pct, int unsigned stall_pct,
                                     logic [QNT_W-1:0] q);
    int unsigned sent;
    int unsigned size;
    int unsigned k;
    int unsigned cap;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    wait_idle();
    write_quantum(q);
    send_idle_pct = send_pct;
    out_stall_pct = stall_pct;
    // keep slices per process bounded so a batch stays short
    cap = ((q == '0) ? 1 : q) * 6;
    if (cap < 16)
      cap = 16;
    if (cap > 65535)
      cap = 65535;
    sent = 0;
    while (sent < RANDOM_BATCH_ITEMS) begin
      // now and then more records than the store holds
      size = ($urandom_range(99) < 8) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4)
                                      : $urandom_range(1, MAX_PROCS);
      for (k = 0; k < size; k++) begin
        arr = ($urandom_range(99) < 70) ? ARR_W'($urandom_range(0, 63))
                                        : ARR_W'($urandom_range(0, 65535));
        bur = ($urandom_range(99) < 4) ? '0 : BUR_W'($urandom_range(1, cap));
        send_record(arr, bur, k == size - 1);
      end
      sent += size;
      if ($urandom_range(99) < 15)
        wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    slice_len = QUANTUM_RESET;
    batch_count = 0;
    mismatches = 0;
    send_idle_pct = 0;
    out_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_single_record();
    test_mixed_batch();
    test_arrival_gaps();
    test_field_extremes();
    test_zero_quantum();
    test_random_batches(0, 0, QNT_W'($urandom_range(2, 9)));
    test_random_batches(76, 0, 16'hFFFF);
    test_random_batches(0, 76, 16'd1);
    test_random_batches(24, 24, QNT_W'($urandom_range(1, 65535)));

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("round_robin_schedule_simulator_top: match");
    else
      $display("round_robin_schedule_simulator_top: mismatch");
    $finish;
  end

endmodule
